>>> hdl/uadp_pkg.sv
// shared constants, types and width helpers for the upwind advection-diffusion point
// no dependencies
`default_nettype none

package uadp_pkg;

  localparam int DATA_WIDTH_DEF  = 32;
  localparam int COEF_WIDTH      = 32;
  localparam int FRAC_BITS       = 24;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIFF_COEF_X = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIFF_COEF_Y = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ADV_COEF_X  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ADV_COEF_Y  = 3'd3;

  // upwind direction: set where the advecting component is strictly positive
  typedef struct packed {
    logic xpos;
    logic ypos;
  } dir_t;

  // width of the advective factor, clamped to 64 bits
  function automatic int k_width(input int w);
    int kw;
    begin
      kw = w + COEF_WIDTH - FRAC_BITS;
      if (kw > 64) begin
        kw = 64;
      end
      return kw;
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/uadp_comp.sv
// update pipeline for one velocity component: diffusion, upwind advection, saturation
// depends on uadp_pkg; advective factors come from the top level, consumed in stage 3
`default_nettype none

module uadp_comp #(
  parameter int DATA_WIDTH = uadp_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic        [uadp_pkg::COEF_WIDTH-1:0] diff_x,
  input  wire logic        [uadp_pkg::COEF_WIDTH-1:0] diff_y,
  input  wire logic signed [DATA_WIDTH-1:0]           q_c,
  input  wire logic signed [DATA_WIDTH-1:0]           q_w,
  input  wire logic signed [DATA_WIDTH-1:0]           q_e,
  input  wire logic signed [DATA_WIDTH-1:0]           q_s,
  input  wire logic signed [DATA_WIDTH-1:0]           q_n,
  input  wire uadp_pkg::dir_t                         dir,
  input  wire logic signed [uadp_pkg::k_width(DATA_WIDTH)-1:0] kx,
  input  wire logic signed [uadp_pkg::k_width(DATA_WIDTH)-1:0] ky,
  output logic signed      [DATA_WIDTH-1:0]           q_new,
  output logic                                        clip
);
  import uadp_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int CW  = COEF_WIDTH;
  localparam int LW  = W + 2;
  localparam int LL  = LW / 2;
  localparam int LU  = LW - LL;
  localparam int DPW = LW + CW + 1;
  localparam int DSW = DPW + 1;
  localparam int DDW = DSW - FRAC_BITS;
  localparam int GW  = W + 1;
  localparam int GL  = GW / 2;
  localparam int GU  = GW - GL;
  localparam int KW  = k_width(W);
  localparam int KL  = KW / 2;
  localparam int KU  = KW - KL;
  localparam int PW  = KW + GW;
  localparam int AW  = PW - FRAC_BITS;
  localparam int RW  = ((AW > DDW) ? AW : DDW) + 2;

  // stage 1: second differences and upwind first differences
  logic signed [LW-1:0] lapx1, lapy1;
  logic signed [GW-1:0] gx1, gy1;
  logic signed [W-1:0]  qc1;

  always_ff @(posedge clk) begin
    if (en) begin
      lapx1 <= LW'(q_e) + LW'(q_w) - (LW'(q_c) <<< 1);
      lapy1 <= LW'(q_n) + LW'(q_s) - (LW'(q_c) <<< 1);
      gx1   <= dir.xpos ? GW'(q_c) - GW'(q_w) : GW'(q_e) - GW'(q_c);
      gy1   <= dir.ypos ? GW'(q_c) - GW'(q_s) : GW'(q_n) - GW'(q_c);
      qc1   <= q_c;
    end
  end

  // stage 2: diffusion partial products, laplacian split in two halves
  logic signed [CW:0]       cdx, cdy;
  logic signed [LL+CW+1:0]  dxl2, dyl2;
  logic signed [LU+CW:0]    dxh2, dyh2;
  logic signed [GW-1:0]     gx2, gy2;
  logic signed [W-1:0]      qc2;

  assign cdx = signed'({1'b0, diff_x});
  assign cdy = signed'({1'b0, diff_y});

  always_ff @(posedge clk) begin
    if (en) begin
      dxl2 <= signed'({1'b0, lapx1[LL-1:0]}) * cdx;
      dxh2 <= signed'(lapx1[LW-1:LL]) * cdx;
      dyl2 <= signed'({1'b0, lapy1[LL-1:0]}) * cdy;
      dyh2 <= signed'(lapy1[LW-1:LL]) * cdy;
      gx2  <= gx1;
      gy2  <= gy1;
      qc2  <= qc1;
    end
  end

  // stage 3: diffusion term, advection partial products
  logic signed [DSW-1:0]      dsum;
  logic signed [DDW-1:0]      d3;
  logic signed [W-1:0]        qc3;
  logic signed [KL+GL+1:0]    kgx_ll3, kgy_ll3;
  logic signed [KL+GU:0]      kgx_lh3, kgy_lh3;
  logic signed [KU+GL:0]      kgx_hl3, kgy_hl3;
  logic signed [KU+GU-1:0]    kgx_hh3, kgy_hh3;

  assign dsum = (DSW'(dxh2) <<< LL) + DSW'(dxl2) + (DSW'(dyh2) <<< LL) + DSW'(dyl2);

  always_ff @(posedge clk) begin
    if (en) begin
      d3      <= DDW'(dsum >>> FRAC_BITS);
      qc3     <= qc2;
      kgx_ll3 <= signed'({1'b0, kx[KL-1:0]}) * signed'({1'b0, gx2[GL-1:0]});
      kgx_lh3 <= signed'({1'b0, kx[KL-1:0]}) * signed'(gx2[GW-1:GL]);
      kgx_hl3 <= signed'(kx[KW-1:KL]) * signed'({1'b0, gx2[GL-1:0]});
      kgx_hh3 <= signed'(kx[KW-1:KL]) * signed'(gx2[GW-1:GL]);
      kgy_ll3 <= signed'({1'b0, ky[KL-1:0]}) * signed'({1'b0, gy2[GL-1:0]});
      kgy_lh3 <= signed'({1'b0, ky[KL-1:0]}) * signed'(gy2[GW-1:GL]);
      kgy_hl3 <= signed'(ky[KW-1:KL]) * signed'({1'b0, gy2[GL-1:0]});
      kgy_hh3 <= signed'(ky[KW-1:KL]) * signed'(gy2[GW-1:GL]);
    end
  end

  // stage 4: recombine advection products and drop fraction
  logic signed [PW-1:0]  psum_x, psum_y;
  logic signed [AW-1:0]  ax4, ay4;
  logic signed [DDW-1:0] d4;
  logic signed [W-1:0]   qc4;

  assign psum_x = (PW'(kgx_hh3) <<< (KL + GL)) + (PW'(kgx_hl3) <<< KL)
                + (PW'(kgx_lh3) <<< GL) + PW'(kgx_ll3);
  assign psum_y = (PW'(kgy_hh3) <<< (KL + GL)) + (PW'(kgy_hl3) <<< KL)
                + (PW'(kgy_lh3) <<< GL) + PW'(kgy_ll3);

  always_ff @(posedge clk) begin
    if (en) begin
      ax4 <= AW'(psum_x >>> FRAC_BITS);
      ay4 <= AW'(psum_y >>> FRAC_BITS);
      d4  <= d3;
      qc4 <= qc3;
    end
  end

  // stage 5: final sum and saturation into the output word
  logic signed [RW-1:0] rsum;
  logic                 fits;

  assign rsum = RW'(qc4) + RW'(d4) - RW'(ax4) - RW'(ay4);
  // in range when every bit above the sign position matches the sign
  assign fits = (&rsum[RW-1:W-1]) | ~(|rsum[RW-1:W-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      clip <= ~fits;
      if (fits) begin
        q_new <= rsum[W-1:0];
      end else if (rsum[RW-1]) begin
        q_new <= signed'({1'b1, {(W-1){1'b0}}});
      end else begin
        q_new <= signed'({1'b0, {(W-1){1'b1}}});
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/upwind_advection_diffusion_point.sv
// upwind advection-diffusion update of one interior grid point (u and v), depends on
// uadp_pkg and uadp_comp. throughput one word per cycle, the five-stage multiply/add
// pipeline advancing as a whole whenever the output register is empty or being taken.
// synchronous reset clears valid bits and the four coefficients to zero.
`default_nettype none

module upwind_advection_diffusion_point #(
  parameter int DATA_WIDTH = uadp_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_write,
  input  wire logic [uadp_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  wire logic [uadp_pkg::COEF_WIDTH-1:0]         cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [DATA_WIDTH-1:0]            u_center,
  input  wire logic signed [DATA_WIDTH-1:0]            u_west,
  input  wire logic signed [DATA_WIDTH-1:0]            u_east,
  input  wire logic signed [DATA_WIDTH-1:0]            u_south,
  input  wire logic signed [DATA_WIDTH-1:0]            u_north,
  input  wire logic signed [DATA_WIDTH-1:0]            v_center,
  input  wire logic signed [DATA_WIDTH-1:0]            v_west,
  input  wire logic signed [DATA_WIDTH-1:0]            v_east,
  input  wire logic signed [DATA_WIDTH-1:0]            v_south,
  input  wire logic signed [DATA_WIDTH-1:0]            v_north,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [DATA_WIDTH-1:0]                 u_new,
  output logic signed [DATA_WIDTH-1:0]                 v_new,
  output logic                                         saturated
);
  import uadp_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int CW     = COEF_WIDTH;
  localparam int STAGES = 5;
  localparam int UL     = W / 2;
  localparam int UU     = W - UL;
  localparam int KFW    = W + CW + 1;
  localparam int KRW    = KFW - FRAC_BITS;
  localparam int KW     = k_width(W);
  localparam logic signed [KW-1:0] KMIN = signed'({1'b1, {(KW-1){1'b0}}});
  localparam logic signed [KW-1:0] KMAX = signed'({1'b0, {(KW-1){1'b1}}});

  // coefficient registers
  logic [CW-1:0] diff_coef_x, diff_coef_y, adv_coef_x, adv_coef_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_coef_x <= '0;
      diff_coef_y <= '0;
      adv_coef_x  <= '0;
      adv_coef_y  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DIFF_COEF_X: diff_coef_x <= cfg_data;
        REG_DIFF_COEF_Y: diff_coef_y <= cfg_data;
        REG_ADV_COEF_X:  adv_coef_x  <= cfg_data;
        REG_ADV_COEF_Y:  adv_coef_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a finished word is held at the output
  logic               en;
  logic [STAGES-1:0]  vld;

  assign en        = ~(vld[STAGES-1] & out_stall);
  assign in_stall  = ~en;
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  dir_t dir;
  assign dir.xpos = ~u_center[W-1] & (|u_center);
  assign dir.ypos = ~v_center[W-1] & (|v_center);

  // advective factors: split products in stage 1, recombine and clamp in stage 2
  logic signed [CW:0]      acx, acy;
  logic signed [UL+CW+1:0] kxl1, kyl1;
  logic signed [UU+CW:0]   kxh1, kyh1;
  logic signed [KFW-1:0]   kfull_x, kfull_y;
  logic signed [KRW-1:0]   kraw_x, kraw_y;
  logic signed [KW-1:0]    kxt, kyt;
  logic signed [KW-1:0]    kx2, ky2;

  assign acx = signed'({1'b0, adv_coef_x});
  assign acy = signed'({1'b0, adv_coef_y});

  always_ff @(posedge clk) begin
    if (en) begin
      kxl1 <= signed'({1'b0, u_center[UL-1:0]}) * acx;
      kxh1 <= signed'(u_center[W-1:UL]) * acx;
      kyl1 <= signed'({1'b0, v_center[UL-1:0]}) * acy;
      kyh1 <= signed'(v_center[W-1:UL]) * acy;
    end
  end

  assign kfull_x = (KFW'(kxh1) <<< UL) + KFW'(kxl1);
  assign kfull_y = (KFW'(kyh1) <<< UL) + KFW'(kyl1);
  assign kraw_x  = KRW'(kfull_x >>> FRAC_BITS);
  assign kraw_y  = KRW'(kfull_y >>> FRAC_BITS);
  assign kxt     = signed'(kraw_x[KW-1:0]);
  assign kyt     = signed'(kraw_y[KW-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (KRW'(kxt) == kraw_x) begin
        kx2 <= kxt;
      end else begin
        kx2 <= kraw_x[KRW-1] ? KMIN : KMAX;
      end
      if (KRW'(kyt) == kraw_y) begin
        ky2 <= kyt;
      end else begin
        ky2 <= kraw_y[KRW-1] ? KMIN : KMAX;
      end
    end
  end

  logic clip_u, clip_v;

  uadp_comp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_comp (
    .clk    (clk),
    .en     (en),
    .diff_x (diff_coef_x),
    .diff_y (diff_coef_y),
    .q_c    (u_center),
    .q_w    (u_west),
    .q_e    (u_east),
    .q_s    (u_south),
    .q_n    (u_north),
    .dir    (dir),
    .kx     (kx2),
    .ky     (ky2),
    .q_new  (u_new),
    .clip   (clip_u)
  );

  uadp_comp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) v_comp (
    .clk    (clk),
    .en     (en),
    .diff_x (diff_coef_x),
    .diff_y (diff_coef_y),
    .q_c    (v_center),
    .q_w    (v_west),
    .q_e    (v_east),
    .q_s    (v_south),
    .q_n    (v_north),
    .dir    (dir),
    .kx     (kx2),
    .ky     (ky2),
    .q_new  (v_new),
    .clip   (clip_v)
  );

  assign saturated = clip_u | clip_v;

endmodule

`default_nettype wire
